FILE: rtl/rrhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhc_pkg: shared types and constants of the receive ring header check
// Header item layout, verdict codes, register indexes and size limits.
// ----------------------------------------------------------------------------
package rrhc_pkg;

  // Verdict codes carried on the result channel
  typedef enum logic [2:0] {
    VERDICT_EMPTY  = 3'd0,
    VERDICT_GOOD   = 3'd1,
    VERDICT_INDEX  = 3'd2,
    VERDICT_SIZE   = 3'd3,
    VERDICT_STATUS = 3'd4
  } verdict_e;

  // Register indexes (word address bit 2)
  localparam logic REG_RING_START = 1'b0;
  localparam logic REG_RING_STOP  = 1'b1;

  // Register reset values
  localparam logic [7:0] RING_START_RST = 8'd70;
  localparam logic [7:0] RING_STOP_RST  = 8'd128;
  localparam logic [7:0] BOUNDARY_RST   = RING_STOP_RST - 8'd1;

  // Frame size limits, count includes the header bytes
  localparam logic [15:0] HDR_BYTES = 16'd4;
  localparam logic [15:0] MIN_LEN   = 16'd60;
  localparam logic [15:0] MAX_LEN   = 16'd1518;
  localparam logic [15:0] MIN_COUNT = MIN_LEN + HDR_BYTES;
  localparam logic [15:0] MAX_COUNT = MAX_LEN + HDR_BYTES;

  // Receive status bits
  localparam logic [7:0] STATUS_MASK = 8'h0f;
  localparam logic [7:0] STATUS_OK   = 8'h01;
  localparam logic [7:0] STATUS_FIFO = 8'h08;

  // Decoupling queue geometry
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Ring configuration seen by the back end
  typedef struct packed {
    logic [7:0] ring_start;
    logic [7:0] ring_stop;
  } cfg_t;

  // Classified header, written into the queue
  typedef struct packed {
    logic [7:0]  write_page;
    logic [7:0]  hdr_next;
    logic [7:0]  count_hi;
    logic [10:0] plen;
    logic        size_ok;
    logic        status_ok;
    logic        fifo_flag;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/rrhc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhc_front: header classification
// Works out the checks that do not depend on ring state: frame size, receive
// status, overrun flag and the page span of the byte count.
// ----------------------------------------------------------------------------
module rrhc_front
  import rrhc_pkg::*;
(
  input  logic [7:0]  write_page_i,
  input  logic [7:0]  hdr_status_i,
  input  logic [7:0]  hdr_next_i,
  input  logic [15:0] hdr_count_i,
  output item_t       item_o
);

  logic [15:0] len_full;

  // Payload length without the header bytes
  assign len_full = hdr_count_i - HDR_BYTES;

  // Pack the classified header
  always_comb begin
    item_o.write_page = write_page_i;
    item_o.hdr_next   = hdr_next_i;
    item_o.count_hi   = hdr_count_i[15:8];
    item_o.plen       = len_full[10:0];
    item_o.size_ok    = (hdr_count_i >= MIN_COUNT) && (hdr_count_i <= MAX_COUNT);
    item_o.status_ok  = ((hdr_status_i & STATUS_MASK) == STATUS_OK);
    item_o.fifo_flag  = |(hdr_status_i & STATUS_FIFO);
  end

endmodule
`default_nettype wire

FILE: rtl/rrhc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhc_queue: short queue between classification and ring walk
// Circular buffer of classified headers with ready/valid on both sides.
// ----------------------------------------------------------------------------
module rrhc_queue
  import rrhc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_data_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rrhc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhc_back: ring walk and statistics
// Takes classified headers from the queue, derives the read page from the
// boundary pointer, checks the next index, moves the boundary, counts
// outcomes and holds the result in the output register.
// ----------------------------------------------------------------------------
module rrhc_back
  import rrhc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output verdict_e    verdict_o,
  output logic [15:0] dma_offset_o,
  output logic [10:0] packet_length_o,
  output logic [7:0]  boundary_out_o,
  output logic        next_wrapped_o,
  output logic [31:0] good_total_o,
  output logic [31:0] index_err_total_o,
  output logic [31:0] size_err_total_o,
  output logic [31:0] fifo_err_total_o
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};

  logic                     out_valid_q;
  verdict_e                 verdict_q, verdict_d;
  logic [15:0]              offset_q, offset_d;
  logic [10:0]              plen_q, plen_d;
  logic                     wrapped_q, wrapped_d;
  logic [7:0]               bnd_q, bnd_d;
  logic [COUNTER_WIDTH-1:0] good_q, index_q, size_q, fifo_q;
  logic                     pop;
  logic [8:0]               frame_inc;
  logic [7:0]               frame;
  logic                     empty;
  logic [9:0]               expect_pg;
  logic signed [10:0]       diff, span;
  logic                     idx_ok;
  logic                     nxt_wrap;
  logic [7:0]               nxt;

  assign pop          = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_ready_o = !out_valid_q || out_ready_i;

  // Read page follows the boundary, wrapping to ring start
  assign frame_inc = {1'b0, bnd_q} + 9'd1;
  assign frame     = (frame_inc >= {1'b0, cfg_i.ring_stop}) ? cfg_i.ring_start
                                                            : frame_inc[7:0];
  assign empty     = (frame == item_i.write_page);

  // Next index must sit count_hi plus one or two pages past the frame, with or without wrap
  assign expect_pg = {2'b00, frame} + 10'd1 + {2'b00, item_i.count_hi};
  assign diff      = signed'({3'b000, item_i.hdr_next}) - signed'({1'b0, expect_pg});
  assign span      = signed'({3'b000, cfg_i.ring_stop}) - signed'({3'b000, cfg_i.ring_start});
  assign idx_ok    = (diff == 11'sd0) || (diff == 11'sd1) ||
                     (diff == -span) || (diff == (11'sd1 - span));

  // Clamp a next pointer at or past ring stop to ring start
  assign nxt_wrap = (item_i.hdr_next >= cfg_i.ring_stop);
  assign nxt      = nxt_wrap ? cfg_i.ring_start : item_i.hdr_next;

  // Classify the frame against the ring
  always_comb begin
    verdict_d = VERDICT_EMPTY;
    offset_d  = '0;
    plen_d    = '0;
    wrapped_d = 1'b0;
    bnd_d     = bnd_q;
    if (!empty) begin
      offset_d = {frame, 8'h00} + HDR_BYTES;
      if (!idx_ok) begin
        verdict_d = VERDICT_INDEX;
        bnd_d     = frame - 8'd1;
      end else begin
        wrapped_d = nxt_wrap;
        bnd_d     = nxt - 8'd1;
        priority if (!item_i.size_ok) begin
          verdict_d = VERDICT_SIZE;
        end else if (item_i.status_ok) begin
          verdict_d = VERDICT_GOOD;
          plen_d    = item_i.plen;
        end else begin
          verdict_d = VERDICT_STATUS;
        end
      end
    end
  end

  // Update ring state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bnd_q       <= BOUNDARY_RST;
      good_q      <= '0;
      index_q     <= '0;
      size_q      <= '0;
      fifo_q      <= '0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        bnd_q <= bnd_d;
        if (verdict_d == VERDICT_GOOD) begin
          good_q <= good_q + CNT_ONE;
        end
        if (verdict_d == VERDICT_INDEX) begin
          index_q <= index_q + CNT_ONE;
        end
        if (verdict_d == VERDICT_SIZE) begin
          size_q <= size_q + CNT_ONE;
        end
        if (verdict_d == VERDICT_STATUS && item_i.fifo_flag) begin
          fifo_q <= fifo_q + CNT_ONE;
        end
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      verdict_q <= verdict_d;
      offset_q  <= offset_d;
      plen_q    <= plen_d;
      wrapped_q <= wrapped_d;
    end
  end

  // Ring state changes only with a new result, so it is the result itself
  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign dma_offset_o      = offset_q;
  assign packet_length_o   = plen_q;
  assign next_wrapped_o    = wrapped_q;
  assign boundary_out_o    = bnd_q;
  assign good_total_o      = 32'(good_q);
  assign index_err_total_o = 32'(index_q);
  assign size_err_total_o  = 32'(size_q);
  assign fifo_err_total_o  = 32'(fifo_q);

`ifndef SYNTHESIS
  a_good_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && verdict_q == VERDICT_GOOD) |->
      ({5'b0, plen_q} >= MIN_LEN && {5'b0, plen_q} <= MAX_LEN))
    else $error("good result with payload length out of range");

  a_empty_holds_bnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && verdict_d == VERDICT_EMPTY) |=> $stable(bnd_q))
    else $error("boundary moved on an empty ring");

  a_good_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && verdict_d == VERDICT_GOOD) |=> $stable(good_q))
    else $error("good counter moved without a good frame");

  a_wrap_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && wrapped_q) |->
      (verdict_q == VERDICT_GOOD || verdict_q == VERDICT_SIZE ||
       verdict_q == VERDICT_STATUS))
    else $error("next pointer wrap flagged on empty ring or index mismatch");
`endif

endmodule
`default_nettype wire

FILE: rtl/rx_ring_header_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rx_ring_header_check: receive ring header check
// Walks a paged receive ring one header at a time: finds the read page from
// the boundary pointer, checks the header, moves the boundary and keeps
// wrapping statistics counters.
//
//   channel   dir  handshake               content
//   s_axis    in   tvalid/tready           tdata: write page, header fields
//   m_axis    out  tvalid/tready           tdata: result, tuser: verdict
//   apb       in   psel/penable/pready     ring_start @0x0, ring_stop @0x4
//
// One header per cycle sustained while m_axis_tready holds; a result passes
// through the queue and then the output register.
// The boundary pointer in the ring walk is updated together with the result.
// A two-entry queue sits between classification and the ring walk; while a
// result waits the queue keeps taking headers until both entries are full.
// Reset clears the boundary to ring_stop minus one and counters to zero.
// ----------------------------------------------------------------------------
module rx_ring_header_check
  import rrhc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // write_page[7:0], hdr_status[15:8], hdr_next[23:16], hdr_count[39:24]
  input  logic [39:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dma_offset[15:0], packet_length[26:16], boundary_out[34:27],
  // next_wrapped[35], good_total[67:36], index_err_total[99:68],
  // size_err_total[131:100], fifo_err_total[163:132], zero[167:164]
  output logic [167:0] m_axis_tdata,
  // verdict[2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t        cfg_q;
  item_t       front_item, queue_item;
  logic        queue_valid, queue_ready;
  verdict_e    verdict;
  logic [15:0] dma_offset;
  logic [10:0] packet_length;
  logic [7:0]  boundary_out;
  logic        next_wrapped;
  logic [31:0] good_total, index_err_total, size_err_total, fifo_err_total;
  logic        cfg_wr;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RING_STOP) ? {24'b0, cfg_q.ring_stop}
                                              : {24'b0, cfg_q.ring_start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_start <= RING_START_RST;
      cfg_q.ring_stop  <= RING_STOP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RING_START) begin
        cfg_q.ring_start <= pwdata[7:0];
      end else begin
        cfg_q.ring_stop <= pwdata[7:0];
      end
    end
  end

  // Classify incoming headers
  rrhc_front u_front (
    .write_page_i (s_axis_tdata[7:0]),
    .hdr_status_i (s_axis_tdata[15:8]),
    .hdr_next_i   (s_axis_tdata[23:16]),
    .hdr_count_i  (s_axis_tdata[39:24]),
    .item_o       (front_item)
  );

  // Decouple intake from the ring walk
  rrhc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_data_i  (front_item),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_data_o  (queue_item)
  );

  // Walk the ring and count outcomes
  rrhc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .item_valid_i      (queue_valid),
    .item_ready_o      (queue_ready),
    .item_i            (queue_item),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .verdict_o         (verdict),
    .dma_offset_o      (dma_offset),
    .packet_length_o   (packet_length),
    .boundary_out_o    (boundary_out),
    .next_wrapped_o    (next_wrapped),
    .good_total_o      (good_total),
    .index_err_total_o (index_err_total),
    .size_err_total_o  (size_err_total),
    .fifo_err_total_o  (fifo_err_total)
  );

  // Pack the result transaction
  assign m_axis_tuser = verdict;
  assign m_axis_tdata = {4'b0000, fifo_err_total, size_err_total, index_err_total,
                         good_total, next_wrapped, boundary_out, packet_length,
                         dma_offset};

endmodule
`default_nettype wire
